// ===== hw/rtl/stepper_step_generator_with_ramp_core_defines.svh =====
// Assertion macros shared by the stepper step generator RTL
`ifndef STEPPER_STEP_GENERATOR_WITH_RAMP_CORE_DEFINES_SVH
`define STEPPER_STEP_GENERATOR_WITH_RAMP_CORE_DEFINES_SVH

// Implication checked on every clock edge outside reset
`define SSG_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ssg: implication check failed");

// Condition that must hold on the edge after reset was sampled
`define SSG_ASSERT_AFTER_RESET(label, clk, rst, cons) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("ssg: reset check failed");

`endif

// ===== hw/rtl/ssg_pkg.sv =====
// Shared types and constants of the stepper step generator
`default_nettype none
package ssg_pkg;

   localparam int FIELD_W    = 20;
   localparam int ACC_W      = 16;
   localparam int POS_PORT_W = 32;
   localparam int OP_W       = 2;
   localparam int KIND_W     = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int QDEPTH     = 2;
   localparam int QPTR_W     = 1;

   localparam logic [FIELD_W-1:0] SPEED_LIMIT = 20'd1000000;
   localparam logic [FIELD_W-1:0] FIELD_MAX   = 20'hFFFFF;

   // Input operation codes
   localparam logic [OP_W-1:0] OP_TICK = 2'd0;
   localparam logic [OP_W-1:0] OP_MOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_SET  = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_INIT_SPEED = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_ACCEL      = 1'b1;

   // Command kinds passed from front to back
   typedef enum logic [KIND_W-1:0] {
      CMD_TICK = 2'd0,
      CMD_MOVE = 2'd1,
      CMD_SET  = 2'd2,
      CMD_NOP  = 2'd3
   } cmd_kind_type;

endpackage
`default_nettype wire

// ===== hw/rtl/ssg_front.sv =====
// Front end: accepts input items and classifies them into commands
`default_nettype none
module ssg_front #(
   parameter int POSITION_BITS = 32
) (
   input  wire logic                          req_push,
   output logic                               req_full,
   input  wire logic [ssg_pkg::OP_W-1:0]      req_op,
   input  wire logic [ssg_pkg::POS_PORT_W-1:0] req_position_value,
   input  wire logic                          q_full,
   output logic                               q_push,
   output ssg_pkg::cmd_kind_type              q_kind,
   output logic [POSITION_BITS-1:0]           q_value
);
   import ssg_pkg::*;

   // Accept while the command queue has room
   assign req_full = q_full;
   assign q_push   = req_push && !q_full;

   // Keep only the position bits in use
   assign q_value = req_position_value[POSITION_BITS-1:0];

   // Classify the operation
   always_comb begin
      unique case (req_op)
         OP_TICK: q_kind = CMD_TICK;
         OP_MOVE: q_kind = CMD_MOVE;
         OP_SET:  q_kind = CMD_SET;
         default: q_kind = CMD_NOP;
      endcase
   end

endmodule
`default_nettype wire

// ===== hw/rtl/ssg_cmdq.sv =====
// Short command queue between front and back
`default_nettype none
module ssg_cmdq #(
   parameter int W = 34
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire logic [W-1:0] din,
   output logic              full,
   input  wire logic         pop,
   output logic [W-1:0]      dout,
   output logic              empty
);
   import ssg_pkg::*;

   logic [W-1:0]      entry_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign full    = (count_ff == (QPTR_W+1)'(QDEPTH));
   assign empty   = (count_ff == '0);
   assign dout    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the item
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= din;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/ssg_div.sv =====
// Restoring divider: tick rate divided by speed, one quotient bit a cycle
`default_nettype none
module ssg_div #(
   parameter int TICKS_PER_SECOND = 1000000
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [ssg_pkg::FIELD_W-1:0] divisor,
   output logic                            done,
   output logic [ssg_pkg::FIELD_W-1:0]     quotient
);
   import ssg_pkg::*;

   localparam int DW = $clog2(TICKS_PER_SECOND + 1);
   localparam int CW = $clog2(DW);
   localparam int QW = (DW > FIELD_W) ? DW : FIELD_W;
   localparam logic [DW-1:0] DIVIDEND = DW'(TICKS_PER_SECOND);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [FIELD_W-1:0] rem_ff, rem_in;
   logic [FIELD_W-1:0] dsr_ff, dsr_in;
   logic [DW-1:0]      quot_ff, quot_in;
   logic [FIELD_W:0]   rem_sh;
   logic [FIELD_W:0]   rem_sub;
   logic               fits;
   logic [QW-1:0]      quot_ext;

   // One restoring step
   assign rem_sh  = {rem_ff, DIVIDEND[cnt_ff]};
   assign fits    = (rem_sh >= {1'b0, dsr_ff});
   assign rem_sub = rem_sh - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(DW - 1);
         rem_in  = '0;
         dsr_in  = divisor;
         quot_in = '0;
      end else if (busy_ff) begin
         rem_in  = fits ? rem_sub[FIELD_W-1:0] : rem_sh[FIELD_W-1:0];
         quot_in = {quot_ff[DW-2:0], fits};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      quot_ff <= quot_in;
   end

   // Saturate the quotient to the interval width
   assign quot_ext = QW'(quot_ff);
   assign quotient = (quot_ext > QW'(FIELD_MAX)) ? FIELD_MAX : quot_ext[FIELD_W-1:0];
   assign done     = done_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/ssg_back.sv =====
// Back end: position, ramp and interval state, result register
`default_nettype none
module ssg_back #(
   parameter int TICKS_PER_SECOND = 1000000,
   parameter int POSITION_BITS    = 32
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [ssg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [ssg_pkg::FIELD_W-1:0]    csr_wdata,
   input  wire logic                           cmd_empty,
   input  wire ssg_pkg::cmd_kind_type          cmd_kind,
   input  wire logic [POSITION_BITS-1:0]       cmd_value,
   output logic                                cmd_pop,
   input  wire logic                           rsp_pop,
   output logic                                rsp_empty,
   output logic                                rsp_step_pulse,
   output logic                                rsp_step_direction,
   output logic [ssg_pkg::POS_PORT_W-1:0]      rsp_current_position,
   output logic [ssg_pkg::FIELD_W-1:0]         rsp_running_speed,
   output logic                                rsp_at_target
);
   import ssg_pkg::*;

   localparam int PW = ACC_W + POSITION_BITS;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_DIST = 6'b000010,
      ST_MUL  = 6'b000100,
      ST_UPD  = 6'b001000,
      ST_DIV  = 6'b010000,
      ST_OUT  = 6'b100000
   } state_type;

   state_type              state_ff, state_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] tgt_ff, tgt_in;
   logic [POSITION_BITS-1:0] dist_ff, dist_in;
   logic [PW-1:0]          prod_ff, prod_in;
   logic [FIELD_W-1:0]     speed_ff, speed_in;
   logic [FIELD_W-1:0]     intv_ff, intv_in;
   logic [FIELD_W-1:0]     ticks_ff, ticks_in;
   logic [ACC_W-1:0]       acc_ff, acc_in;
   logic                   pulse_ff, pulse_in;
   logic                   dir_ff, dir_in;
   logic                   emit_ff, emit_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_pulse_ff, rsp_pulse_in;
   logic                   rsp_dir_ff, rsp_dir_in;
   logic [POSITION_BITS-1:0] rsp_pos_ff, rsp_pos_in;
   logic [FIELD_W-1:0]     rsp_speed_ff, rsp_speed_in;
   logic                   rsp_at_ff, rsp_at_in;

   logic [FIELD_W-1:0]     ticks_inc;
   logic [FIELD_W:0]       speed_sum;
   logic [FIELD_W-1:0]     speed_ramp;
   logic [FIELD_W-1:0]     speed_next;
   logic [FIELD_W-1:0]     csr_speed;
   logic                   grow;
   logic                   go_up;
   logic                   div_start;
   logic [FIELD_W-1:0]     div_divisor;
   logic                   div_done;
   logic [FIELD_W-1:0]     div_quot;

   ssg_div #(
      .TICKS_PER_SECOND(TICKS_PER_SECOND)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .divisor (div_divisor),
      .done    (div_done),
      .quotient(div_quot)
   );

   // Datapath helpers
   assign ticks_inc  = (ticks_ff == FIELD_MAX) ? ticks_ff : ticks_ff + 1'b1;
   assign speed_sum  = {1'b0, speed_ff} + (FIELD_W+1)'(acc_ff);
   assign speed_ramp = (speed_sum > {1'b0, SPEED_LIMIT}) ? SPEED_LIMIT
                                                          : speed_sum[FIELD_W-1:0];
   assign grow       = (acc_ff != '0) && (PW'(speed_ff) < prod_ff);
   assign speed_next = grow ? speed_ramp : speed_ff;
   assign csr_speed  = (csr_wdata > SPEED_LIMIT) ? SPEED_LIMIT : csr_wdata;
   assign go_up      = pos_ff < tgt_ff;

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      tgt_in       = tgt_ff;
      dist_in      = dist_ff;
      prod_in      = prod_ff;
      speed_in     = speed_ff;
      intv_in      = intv_ff;
      ticks_in     = ticks_ff;
      acc_in       = acc_ff;
      pulse_in     = pulse_ff;
      dir_in       = dir_ff;
      emit_in      = emit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      rsp_pulse_in = rsp_pulse_ff;
      rsp_dir_in   = rsp_dir_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_speed_in = rsp_speed_ff;
      rsp_at_in    = rsp_at_ff;
      cmd_pop      = 1'b0;
      div_start    = 1'b0;
      div_divisor  = speed_ff;

      unique case (state_ff)
         // Take the next command and apply its position or target change
         ST_IDLE: begin
            if (!csr_we && !cmd_empty) begin
               cmd_pop  = 1'b1;
               pulse_in = 1'b0;
               emit_in  = 1'b1;
               unique case (cmd_kind)
                  CMD_TICK: begin
                     if (ticks_inc >= intv_ff && pos_ff != tgt_ff) begin
                        pulse_in = 1'b1;
                        dir_in   = go_up;
                        pos_in   = go_up ? pos_ff + 1'b1 : pos_ff - 1'b1;
                        ticks_in = '0;
                        state_in = ST_DIST;
                     end else begin
                        ticks_in = ticks_inc;
                        state_in = ST_OUT;
                     end
                  end
                  CMD_MOVE: begin
                     tgt_in   = cmd_value;
                     state_in = ST_DIST;
                  end
                  CMD_SET: begin
                     pos_in   = cmd_value;
                     state_in = ST_OUT;
                  end
                  default: begin
                     state_in = ST_OUT;
                  end
               endcase
            end
         end
         // Remaining distance
         ST_DIST: begin
            dist_in  = (tgt_ff >= pos_ff) ? tgt_ff - pos_ff : pos_ff - tgt_ff;
            state_in = ST_MUL;
         end
         // Ramp limit: acceleration times distance
         ST_MUL: begin
            prod_in  = PW'(acc_ff) * PW'(dist_ff);
            state_in = ST_UPD;
         end
         // Grow the speed and, if it is nonzero, start the interval reload
         ST_UPD: begin
            speed_in = speed_next;
            if (speed_next != '0) begin
               div_start   = 1'b1;
               div_divisor = speed_next;
               state_in    = ST_DIV;
            end else begin
               state_in = ST_OUT;
            end
         end
         // Wait for the interval
         ST_DIV: begin
            if (div_done) begin
               intv_in  = div_quot;
               state_in = emit_ff ? ST_OUT : ST_IDLE;
            end
         end
         // Load the result register once it is free
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_pop) begin
               rsp_valid_in = 1'b1;
               rsp_pulse_in = pulse_ff;
               rsp_dir_in   = pulse_ff ? dir_ff : (tgt_ff > pos_ff);
               rsp_pos_in   = pos_ff;
               rsp_speed_in = speed_ff;
               rsp_at_in    = (pos_ff == tgt_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Register writes reload the interval, unless the divisor is zero, without producing a result
      if (csr_we) begin
         emit_in = 1'b0;
         if (csr_index == REG_INIT_SPEED) begin
            speed_in    = csr_speed;
            div_divisor = csr_speed;
         end else begin
            acc_in      = csr_wdata[ACC_W-1:0];
            div_divisor = speed_ff;
         end
         if (div_divisor != '0) begin
            div_start = 1'b1;
            state_in  = ST_DIV;
         end else begin
            state_in = ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         tgt_ff       <= '0;
         speed_ff     <= '0;
         intv_ff      <= '0;
         ticks_ff     <= '0;
         acc_ff       <= '0;
         emit_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         tgt_ff       <= tgt_in;
         speed_ff     <= speed_in;
         intv_ff      <= intv_in;
         ticks_ff     <= ticks_in;
         acc_ff       <= acc_in;
         emit_ff      <= emit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold payload
   always_ff @(posedge clock) begin
      dist_ff      <= dist_in;
      prod_ff      <= prod_in;
      pulse_ff     <= pulse_in;
      dir_ff       <= dir_in;
      rsp_pulse_ff <= rsp_pulse_in;
      rsp_dir_ff   <= rsp_dir_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_speed_ff <= rsp_speed_in;
      rsp_at_ff    <= rsp_at_in;
   end

   assign rsp_empty            = !rsp_valid_ff;
   assign rsp_step_pulse       = rsp_pulse_ff;
   assign rsp_step_direction   = rsp_dir_ff;
   assign rsp_current_position = POS_PORT_W'(rsp_pos_ff);
   assign rsp_running_speed    = rsp_speed_ff;
   assign rsp_at_target        = rsp_at_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/stepper_step_generator_with_ramp_core.sv =====
// Top level of the stepper step generator with linear speed ramp
//
// Input items (req_*) are pushed while req_full is low: op 0 is a one-tick
// advance, op 1 sets the target, op 2 loads the position, op 3 does nothing.
// Every item yields one result on the rsp_* queue: step pulse, direction,
// position, running speed and at-target flag; pop it while rsp_empty is low.
// The csr_* port writes initial_speed (index 0) or acceleration_step (1);
// it is to be used only while no item is in flight; the block does not enforce this.
// An item passes from the command queue to the back's IDLE state; steps and moves
// then pass DIST, MUL and UPD and, unless the speed is left at zero, DIV, where the
// interval divider finds one quotient bit a cycle, before OUT loads the result
// register; other items go from IDLE straight to OUT. The back carries out one item
// at a time. A register write also starts a divider run, unless the divisor is zero,
// and keeps the back busy until it ends.
// A two-entry command queue lets items be taken while the back works or a
// result waits; with rsp_pop held low the result register holds, the back
// stalls and req_full rises once the queue is full.
// Synchronous reset clears positions, speed, interval, tick count and both
// registers, and empties both queues.
`default_nettype none
`include "stepper_step_generator_with_ramp_core_defines.svh"
module stepper_step_generator_with_ramp_core #(
   parameter int TICKS_PER_SECOND = 1000000,
   parameter int POSITION_BITS    = 32
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_push,
   output logic                                req_full,
   input  wire logic [ssg_pkg::OP_W-1:0]       req_op,
   input  wire logic [ssg_pkg::POS_PORT_W-1:0] req_position_value,
   input  wire logic                           rsp_pop,
   output logic                                rsp_empty,
   output logic                                rsp_step_pulse,
   output logic                                rsp_step_direction,
   output logic [ssg_pkg::POS_PORT_W-1:0]      rsp_current_position,
   output logic [ssg_pkg::FIELD_W-1:0]         rsp_running_speed,
   output logic                                rsp_at_target,
   input  wire logic                           csr_we,
   input  wire logic [ssg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [ssg_pkg::FIELD_W-1:0]    csr_wdata
);
   import ssg_pkg::*;

   localparam int QW = KIND_W + POSITION_BITS;

   logic                     q_push;
   logic                     q_full;
   logic                     q_pop;
   logic                     q_empty;
   cmd_kind_type             front_kind;
   logic [POSITION_BITS-1:0] front_value;
   logic [QW-1:0]            q_din;
   logic [QW-1:0]            q_dout;
   cmd_kind_type             back_kind;
   logic                     rsp_idle_at_target;

   // Classify incoming items
   ssg_front #(
      .POSITION_BITS(POSITION_BITS)
   ) u_front (
      .req_push          (req_push),
      .req_full          (req_full),
      .req_op            (req_op),
      .req_position_value(req_position_value),
      .q_full            (q_full),
      .q_push            (q_push),
      .q_kind            (front_kind),
      .q_value           (front_value)
   );

   // Queue commands between front and back
   assign q_din     = {front_kind, front_value};
   assign back_kind = cmd_kind_type'(q_dout[QW-1 -: KIND_W]);

   ssg_cmdq #(
      .W(QW)
   ) u_cmdq (
      .clock(clock),
      .reset(reset),
      .push (q_push),
      .din  (q_din),
      .full (q_full),
      .pop  (q_pop),
      .dout (q_dout),
      .empty(q_empty)
   );

   // Carry out commands
   ssg_back #(
      .TICKS_PER_SECOND(TICKS_PER_SECOND),
      .POSITION_BITS   (POSITION_BITS)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .cmd_empty           (q_empty),
      .cmd_kind            (back_kind),
      .cmd_value           (q_dout[POSITION_BITS-1:0]),
      .cmd_pop             (q_pop),
      .rsp_pop             (rsp_pop),
      .rsp_empty           (rsp_empty),
      .rsp_step_pulse      (rsp_step_pulse),
      .rsp_step_direction  (rsp_step_direction),
      .rsp_current_position(rsp_current_position),
      .rsp_running_speed   (rsp_running_speed),
      .rsp_at_target       (rsp_at_target)
   );

   // Result waiting at the target without a step
   assign rsp_idle_at_target = !rsp_empty && rsp_at_target && !rsp_step_pulse;

   // Checks
   `SSG_ASSERT_IMPLY(a_speed_range, clock, reset, !rsp_empty, rsp_running_speed <= SPEED_LIMIT)
   `SSG_ASSERT_IMPLY(a_idle_dir, clock, reset, rsp_idle_at_target, !rsp_step_direction)
   `SSG_ASSERT_AFTER_RESET(a_reset_empty, clock, reset, rsp_empty && !req_full && !q_pop)

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the stepper step generator with a ramp predictor
`default_nettype none
module testbench;
   import ssg_pkg::*;

   localparam logic [OP_W-1:0] OP_NOP        = 2'd3;   // unused code, leaves state alone
   localparam logic [31:0]     TICKS_PER_SEC = 32'd1000000;
   localparam int PHASES          = 7;
   localparam int ITEMS_PER_PHASE = 85;
   localparam int SETTLE_CYCLES   = 40;
   localparam int HOLD_CYCLES     = 300;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int SCRIPT_ROWS     = 20;

   typedef struct packed {
      logic                  pulse;
      logic                  dir;
      logic [POS_PORT_W-1:0] position;
      logic [FIELD_W-1:0]    speed;
      logic                  arrived;
   } motion_type;

   typedef struct packed {
      logic [OP_W-1:0]       op;
      logic [POS_PORT_W-1:0] value;
      logic                  typed;
      motion_type            want;
   } script_row_type;

   localparam motion_type NO_WANT = '0;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_push = 1'b0;
   logic                  req_full;
   logic [OP_W-1:0]       req_op = OP_TICK;
   logic [POS_PORT_W-1:0] req_position_value = '0;
   logic                  rsp_pop = 1'b0;
   logic                  rsp_empty;
   logic                  rsp_step_pulse;
   logic                  rsp_step_direction;
   logic [POS_PORT_W-1:0] rsp_current_position;
   logic [FIELD_W-1:0]    rsp_running_speed;
   logic                  rsp_at_target;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = REG_INIT_SPEED;
   logic [FIELD_W-1:0]    csr_wdata = '0;

   // Predicted block state
   logic [POS_PORT_W-1:0] pos_m;
   logic [POS_PORT_W-1:0] target_m;
   logic [FIELD_W-1:0]    speed_m;
   logic [FIELD_W-1:0]    interval_m;
   logic [FIELD_W-1:0]    ticks_m;
   logic [ACC_W-1:0]      accel_m;

   motion_type motion_due[$];
   int         mismatches = 0;
   bit         steady = 1'b0;
   bit         hold_request = 1'b0;

   // Register settings per phase; phase 0 runs on the reset values
   logic [FIELD_W-1:0] phase_speed [PHASES] = '{20'd0, 20'hFFFFF, 20'd0, 20'd100000,
                                                 20'd1, 20'd300000, 20'd999999};
   logic [ACC_W-1:0]   phase_accel [PHASES] = '{16'd0, 16'd0, 16'd0, 16'hFFFF,
                                                 16'd40000, 16'd2500, 16'd1};

   // Opening script: typed results only where the reset state makes them obvious
   script_row_type opening_script [SCRIPT_ROWS] = '{
      '{OP_TICK, 32'h0,        1'b1, '{1'b0, 1'b0, 32'h0,        20'd0, 1'b1}},
      '{OP_SET,  32'hFFFFFFFF, 1'b1, '{1'b0, 1'b0, 32'hFFFFFFFF, 20'd0, 1'b0}},
      '{OP_TICK, 32'h0,        1'b1, '{1'b1, 1'b0, 32'hFFFFFFFE, 20'd0, 1'b0}},
      '{OP_MOVE, 32'hFFFFFFFF, 1'b1, '{1'b0, 1'b1, 32'hFFFFFFFE, 20'd0, 1'b0}},
      '{OP_TICK, 32'h0,        1'b1, '{1'b1, 1'b1, 32'hFFFFFFFF, 20'd0, 1'b1}},
      '{OP_TICK, 32'hFFFFFFFF, 1'b1, '{1'b0, 1'b0, 32'hFFFFFFFF, 20'd0, 1'b1}},
      '{OP_NOP,  32'h5A5A5A5A, 1'b1, '{1'b0, 1'b0, 32'hFFFFFFFF, 20'd0, 1'b1}},
      '{OP_MOVE, 32'h0,        1'b1, '{1'b0, 1'b0, 32'hFFFFFFFF, 20'd0, 1'b0}},
      '{OP_TICK, 32'h0,        1'b1, '{1'b1, 1'b0, 32'hFFFFFFFE, 20'd0, 1'b0}},
      '{OP_SET,  32'h0,        1'b1, '{1'b0, 1'b0, 32'h0,        20'd0, 1'b1}},
      '{OP_SET,  32'h7FFFFFFF, 1'b0, NO_WANT},
      '{OP_MOVE, 32'h80000000, 1'b0, NO_WANT},
      '{OP_TICK, 32'h0,        1'b0, NO_WANT},
      '{OP_NOP,  32'hFFFFFFFF, 1'b0, NO_WANT},
      '{OP_MOVE, 32'hAAAAAAAA, 1'b0, NO_WANT},
      '{OP_SET,  32'h55555555, 1'b0, NO_WANT},
      '{OP_TICK, 32'hFFFFFFFF, 1'b0, NO_WANT},
      '{OP_MOVE, 32'h55555554, 1'b0, NO_WANT},
      '{OP_TICK, 32'h0,        1'b0, NO_WANT},
      '{OP_TICK, 32'h12345678, 1'b0, NO_WANT}
   };

   stepper_step_generator_with_ramp_core DUT (
      .clock                (clock),
      .reset                (reset),
      .req_push             (req_push),
      .req_full             (req_full),
      .req_op               (req_op),
      .req_position_value   (req_position_value),
      .rsp_pop              (rsp_pop),
      .rsp_empty            (rsp_empty),
      .rsp_step_pulse       (rsp_step_pulse),
      .rsp_step_direction   (rsp_step_direction),
      .rsp_current_position (rsp_current_position),
      .rsp_running_speed    (rsp_running_speed),
      .rsp_at_target        (rsp_at_target),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Recompute the step interval; a zero speed keeps the old one
   function automatic void retime_steps();
      logic [31:0] quotient;
      if (speed_m == '0) return;
      quotient = TICKS_PER_SEC / {12'd0, speed_m};
      interval_m = (quotient > {12'd0, FIELD_MAX}) ? FIELD_MAX : quotient[FIELD_W-1:0];
   endfunction

   // Raise the speed while it is below acceleration times remaining distance
   function automatic void ramp_speed();
      logic [31:0]      distance;
      logic [47:0]      ceiling;
      logic [FIELD_W:0] raised;
      if (accel_m != '0) begin
         distance = (target_m >= pos_m) ? target_m - pos_m : pos_m - target_m;
         ceiling  = 48'(accel_m) * 48'(distance);
         if (48'(speed_m) < ceiling) begin
            raised  = 21'(speed_m) + 21'(accel_m);
            speed_m = (raised > 21'(SPEED_LIMIT)) ? SPEED_LIMIT : raised[FIELD_W-1:0];
         end
      end
      retime_steps();
   endfunction

   // Advance the predicted state by one item and return its result
   function automatic motion_type advance_motor(input logic [OP_W-1:0] op,
                                                input logic [POS_PORT_W-1:0] value);
      motion_type r;
      r = '0;
      case (op)
         OP_TICK: begin
            if (ticks_m < FIELD_MAX) ticks_m = ticks_m + 1'b1;
            if (ticks_m >= interval_m && pos_m != target_m) begin
               r.pulse = 1'b1;
               r.dir   = pos_m < target_m;
               pos_m   = r.dir ? pos_m + 32'd1 : pos_m - 32'd1;
               ticks_m = '0;
               ramp_speed();
            end
         end
         OP_MOVE: begin
            target_m = value;
            ramp_speed();
         end
         OP_SET: pos_m = value;
         default: ;
      endcase
      if (!r.pulse) r.dir = target_m > pos_m;
      r.position = pos_m;
      r.speed    = speed_m;
      r.arrived  = pos_m == target_m;
      return r;
   endfunction

   function automatic void apply_reg(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [FIELD_W-1:0] value);
      case (idx)
         REG_INIT_SPEED: begin
            speed_m = (value > SPEED_LIMIT) ? SPEED_LIMIT : value;
            retime_steps();
         end
         REG_ACCEL: begin
            accel_m = value[ACC_W-1:0];
            retime_steps();
         end
         default: ;
      endcase
   endfunction

   // Mostly no gap, some short ones, a few long; no gap at all while steady
   function automatic int next_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady) return 0;
      if (r < 65) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(15, 60);
   endfunction

   // Offer one item, hold until taken, then log its expected result
   task automatic send_item(input logic [OP_W-1:0] op, input logic [POS_PORT_W-1:0] value,
                            input logic typed, input motion_type want);
      motion_type predicted;
      int         gap;
      req_op             <= op;
      req_position_value <= value;
      req_push           <= 1'b1;
      do @(posedge clock); while (req_full);
      predicted = advance_motor(op, value);
      motion_due.push_back(typed ? want : predicted);
      gap = next_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [FIELD_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      apply_reg(idx, value);
   endtask

   // Wait for every expected result, then let the divider settle
   task automatic drain();
      while (motion_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Random moves followed by tick bursts, with loads, far targets and noise mixed in
   task automatic wander(input int count);
      int                    sent;
      int                    pick;
      logic [POS_PORT_W-1:0] value;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            value = pos_m + $urandom_range(0, 40) - 32'd20;
            send_item(OP_MOVE, value, 1'b0, NO_WANT);
            sent++;
            repeat ($urandom_range(1, 48)) begin
               send_item(OP_TICK, $urandom(), 1'b0, NO_WANT);
               sent++;
            end
         end else if (pick < 75) begin
            // far target: the distance uses the whole word
            send_item(OP_MOVE, $urandom(), 1'b0, NO_WANT);
            sent++;
            repeat ($urandom_range(1, 12)) begin
               send_item(OP_TICK, $urandom(), 1'b0, NO_WANT);
               sent++;
            end
         end else if (pick < 85) begin
            value = ($urandom_range(0, 1) == 0) ? $urandom()
                                                : target_m + $urandom_range(0, 6) - 32'd3;
            send_item(OP_SET, value, 1'b0, NO_WANT);
            sent++;
         end else if (pick < 92) begin
            send_item(OP_NOP, $urandom(), 1'b0, NO_WANT);
            sent++;
         end else begin
            send_item(OP_TICK, $urandom(), 1'b0, NO_WANT);
            sent++;
         end
      end
   endtask

   task automatic check_motion(input motion_type got);
      motion_type want;
      if (motion_due.size() == 0) begin
         $error("result with nothing expected: position %0h", got.position);
         mismatches++;
         return;
      end
      want = motion_due.pop_front();
      if (got.pulse !== want.pulse) begin
         $error("step_pulse: expected %0d, got %0d", want.pulse, got.pulse);
         mismatches++;
      end
      if (got.dir !== want.dir) begin
         $error("step_direction: expected %0d, got %0d", want.dir, got.dir);
         mismatches++;
      end
      if (got.position !== want.position) begin
         $error("current_position: expected %0h, got %0h", want.position, got.position);
         mismatches++;
      end
      if (got.speed !== want.speed) begin
         $error("running_speed: expected %0d, got %0d", want.speed, got.speed);
         mismatches++;
      end
      if (got.arrived !== want.arrived) begin
         $error("at_target: expected %0d, got %0d", want.arrived, got.arrived);
         mismatches++;
      end
   endtask

   // Take results, idle at random, and hold off for a long stretch on request
   initial begin : result_side
      motion_type got;
      int         hold_left;
      int         gap_left;
      hold_left = 0;
      gap_left  = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            got.pulse    = rsp_step_pulse;
            got.dir      = rsp_step_direction;
            got.position = rsp_current_position;
            got.speed    = rsp_running_speed;
            got.arrived  = rsp_at_target;
            check_motion(got);
         end
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop  <= 1'b1;
            gap_left = next_gap();
         end
      end
   end

   // Drop the run if nothing moves on either side for too long
   initial begin : watchdog
      int idle;
      idle = 0;
      forever begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) idle = 0;
         else idle++;
         if (idle >= WATCHDOG_LIMIT) begin
            $display("FAIL stepper_step_generator_with_ramp_core");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int row;
      int ph;
      pos_m      = '0;
      target_m   = '0;
      speed_m    = '0;
      interval_m = '0;
      ticks_m    = '0;
      accel_m    = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (row = 0; row < SCRIPT_ROWS; row++)
         send_item(opening_script[row].op, opening_script[row].value,
                   opening_script[row].typed, opening_script[row].want);
      wander(80);

      // Step through register settings, starting the writes only once the block is idle
      for (ph = 1; ph < PHASES; ph++) begin
         req_push <= 1'b0;
         drain();
         write_reg(REG_INIT_SPEED, phase_speed[ph]);
         write_reg(REG_ACCEL, FIELD_W'(phase_accel[ph]));
         csr_we <= 1'b0;
         steady = (ph == 2) || (ph == 5);
         if (ph == 3) hold_request = 1'b1;
         wander(ITEMS_PER_PHASE);
      end

      req_push <= 1'b0;
      drain();
      if (mismatches == 0) begin
         $display("PASS stepper_step_generator_with_ramp_core");
      end else begin
         $display("FAIL stepper_step_generator_with_ramp_core");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/ssg_pkg.sv
hw/rtl/ssg_front.sv
hw/rtl/ssg_cmdq.sv
hw/rtl/ssg_div.sv
hw/rtl/ssg_back.sv
hw/rtl/stepper_step_generator_with_ramp_core.sv
tb/sv/testbench.sv
